FILE: sv/ftll_pkg.sv
// shared widths, codes and control structs of the fat tree next-hop switch
package ftll_pkg;

	localparam int ADDR_W  = 12;
	localparam int FLOW_W  = 10;
	localparam int LOAD_W  = 11;
	localparam int LFSR_W  = 16;
	localparam int STAT_W  = 2;
	localparam int KIND_W  = 3;

	localparam int TREE_K_DEF = 8;
	localparam int FLOWS_DEF  = 1024;

	// cycles from a new address to valid decode outputs
	localparam int DEC_LAT   = 3;
	// remainder bits resolved per cycle
	localparam int MOD_CHUNK = 8;

	localparam logic [LOAD_W-1:0] LOAD_MAX  = LOAD_W'(2047);
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOROUTE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ABSENT  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_HOST    = 2'd3;

	localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HOST = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EDGE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_AGGR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CORE = 3'd4;

	typedef struct packed {
		logic acc;
		logic clr;
		logic route;
		logic ties;
		logic sel;
		logic fin;
	} ftll_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_pick;
		logic mod_done;
		logic out_free;
	} ftll_sts_t;

endpackage

FILE: sv/ftll_addr_dec.sv
// three-stage address decoder: node kind, offset and base-half digits
module ftll_addr_dec #(
	parameter int TREE_K = ftll_pkg::TREE_K_DEF
) (
	input  logic                          clk,
	input  logic [ftll_pkg::ADDR_W-1:0]   addr,
	output logic [ftll_pkg::KIND_W-1:0]   kind,
	output logic [ftll_pkg::ADDR_W-1:0]   x,
	output logic [ftll_pkg::ADDR_W-1:0]   q1,
	output logic [ftll_pkg::ADDR_W-1:0]   q2,
	output logic [$clog2(TREE_K/2)-1:0]   r1,
	output logic [$clog2(TREE_K/2)-1:0]   r2
);
	import ftll_pkg::*;

	localparam int HALF      = TREE_K / 2;
	localparam int HIDX_W    = $clog2(HALF);
	localparam int NHOSTS    = TREE_K * TREE_K * TREE_K / 4;
	localparam int AGGR_BASE = NHOSTS + TREE_K * TREE_K / 2;
	localparam int CORE_BASE = NHOSTS + TREE_K * TREE_K;
	localparam int NCORES    = TREE_K * TREE_K / 4;
	// reciprocal scaling is exact for every 12-bit operand
	localparam int DIV_SH    = ADDR_W + HIDX_W + 1;
	localparam int PROD_W    = ADDR_W + DIV_SH;
	localparam logic [DIV_SH-1:0] RECIP  = DIV_SH'((1 << DIV_SH) / HALF + 1);
	localparam logic [ADDR_W-1:0] HALF_A = ADDR_W'(HALF);

	logic [KIND_W-1:0] kind_c;
	logic [ADDR_W-1:0] off_c;
	logic [ADDR_W-1:0] x_c;
	logic [PROD_W-1:0] prod1;
	logic [PROD_W-1:0] prod2;
	logic [ADDR_W-1:0] r1_full;
	logic [ADDR_W-1:0] r2_full;

	logic [KIND_W-1:0] kind_s1, kind_s2, kind_s3;
	logic [ADDR_W-1:0] x_s1, x_s2, x_s3;
	logic [ADDR_W-1:0] q1_s1, q1_s2, q1_s3;
	logic [ADDR_W-1:0] q2_s2, q2_s3;
	logic [HIDX_W-1:0] r1_s2, r1_s3;
	logic [HIDX_W-1:0] r2_s3;

	always_comb begin
		kind_c = KIND_NONE;
		off_c  = '0;
		if (addr >= ADDR_W'(1) && addr <= ADDR_W'(NHOSTS)) begin
			kind_c = KIND_HOST;
			off_c  = ADDR_W'(1);
		end else if (addr > ADDR_W'(NHOSTS) && addr <= ADDR_W'(AGGR_BASE)) begin
			kind_c = KIND_EDGE;
			off_c  = ADDR_W'(NHOSTS + 1);
		end else if (addr > ADDR_W'(AGGR_BASE) && addr <= ADDR_W'(CORE_BASE)) begin
			kind_c = KIND_AGGR;
			off_c  = ADDR_W'(AGGR_BASE + 1);
		end else if (addr > ADDR_W'(CORE_BASE) && addr <= ADDR_W'(CORE_BASE + NCORES)) begin
			kind_c = KIND_CORE;
			off_c  = ADDR_W'(CORE_BASE + 1);
		end
	end

	assign x_c   = addr - off_c;
	assign prod1 = PROD_W'(x_c) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		kind_s1 <= kind_c;
		x_s1    <= x_c;
		q1_s1   <= prod1[DIV_SH +: ADDR_W];
	end

	// second digit and first remainder
	assign prod2   = PROD_W'(q1_s1) * PROD_W'(RECIP);
	assign r1_full = x_s1 - q1_s1 * HALF_A;

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		x_s2    <= x_s1;
		q1_s2   <= q1_s1;
		q2_s2   <= prod2[DIV_SH +: ADDR_W];
		r1_s2   <= r1_full[HIDX_W-1:0];
	end

	assign r2_full = q1_s2 - q2_s2 * HALF_A;

	always_ff @(posedge clk) begin
		kind_s3 <= kind_s2;
		x_s3    <= x_s2;
		q1_s3   <= q1_s2;
		q2_s3   <= q2_s2;
		r1_s3   <= r1_s2;
		r2_s3   <= r2_full[HIDX_W-1:0];
	end

	assign kind = kind_s3;
	assign x    = x_s3;
	assign q1   = q1_s3;
	assign q2   = q2_s3;
	assign r1   = r1_s3;
	assign r2   = r2_s3;

endmodule

FILE: sv/ftll_mod_unit.sv
// remainder of the lfsr value by the tie count, one byte of dividend per cycle
module ftll_mod_unit #(
	parameter int DEN_W = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ftll_pkg::LFSR_W-1:0]  num,
	input  logic [DEN_W-1:0]             den,
	output logic                         done,
	output logic [DEN_W-1:0]             rem
);
	import ftll_pkg::*;

	localparam int CHUNKS = LFSR_W / MOD_CHUNK;
	localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	logic              run_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LFSR_W-1:0] num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  rem_c;
	logic [DEN_W:0]    trial;

	// restoring remainder steps, msb first
	always_comb begin
		rem_c = rem_q;
		trial = '0;
		for (int i = 0; i < MOD_CHUNK; i++) begin
			trial = {rem_c, num_q[LFSR_W-1-i]};
			if (trial >= {1'b0, den_q})
				trial = trial - {1'b0, den_q};
			rem_c = trial[DEN_W-1:0];
		end
	end

	assign done = run_q && (cnt_q == CNT_W'(CHUNKS - 1));
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= CNT_W'(cnt_q + 1'b1);
			if (done)
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << MOD_CHUNK;
			rem_q <= rem_c;
		end
	end

endmodule

FILE: sv/ftll_ctrl.sv
// sequencer: memory clear, accept, decode wait, route, tie break, write-back
module ftll_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output ftll_pkg::ftll_cmd_t  cmd,
	input  ftll_pkg::ftll_sts_t  sts
);
	import ftll_pkg::*;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DEC   = 3'd2;
	localparam logic [2:0] ST_ROUTE = 3'd3;
	localparam logic [2:0] ST_TIES  = 3'd4;
	localparam logic [2:0] ST_MOD   = 3'd5;
	localparam logic [2:0] ST_SEL   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	localparam int DCNT_W = $clog2(DEC_LAT);

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [DCNT_W-1:0] dcnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.acc = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (dcnt_q == DCNT_W'(DEC_LAT - 1))
					state_d = ST_ROUTE;
			end
			ST_ROUTE: begin
				cmd.route = 1'b1;
				state_d   = sts.need_pick ? ST_TIES : ST_FIN;
			end
			ST_TIES: begin
				cmd.ties = 1'b1;
				state_d  = ST_MOD;
			end
			ST_MOD: begin
				if (sts.mod_done)
					state_d = ST_SEL;
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register can take the item
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DEC)
				dcnt_q <= DCNT_W'(dcnt_q + 1'b1);
			else
				dcnt_q <= '0;
		end
	end

endmodule

FILE: sv/ftll_dp.sv
// datapath: flow tables, uplink counters, route decision and output register
module ftll_dp #(
	parameter int TREE_K = ftll_pkg::TREE_K_DEF,
	parameter int FLOWS  = ftll_pkg::FLOWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ftll_pkg::ADDR_W-1:0]  cfg_wdata,
	input  logic                         action,
	input  logic [ftll_pkg::FLOW_W-1:0]  flow_id,
	input  logic [ftll_pkg::ADDR_W-1:0]  src_addr,
	input  logic [ftll_pkg::ADDR_W-1:0]  dst_addr,
	input  ftll_pkg::ftll_cmd_t          cmd,
	output ftll_pkg::ftll_sts_t          sts,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [ftll_pkg::ADDR_W-1:0]  hop_addr,
	output logic [ftll_pkg::STAT_W-1:0]  status
);
	import ftll_pkg::*;

	localparam int HALF      = TREE_K / 2;
	localparam int HIDX_W    = $clog2(HALF);
	localparam int TIE_W     = $clog2(HALF + 1);
	localparam int NHOSTS    = TREE_K * TREE_K * TREE_K / 4;
	localparam int EDGE_BASE = NHOSTS;
	localparam int AGGR_BASE = NHOSTS + TREE_K * TREE_K / 2;
	localparam int CORE_BASE = NHOSTS + TREE_K * TREE_K;
	localparam int FIDX_W    = $clog2(FLOWS);
	localparam int FCMP_W    = (($clog2(FLOWS + 1) > FLOW_W) ? $clog2(FLOWS + 1) : FLOW_W) + 1;

	// configuration and captured item
	logic [ADDR_W-1:0] node_q;
	logic              act_q;
	logic [FLOW_W-1:0] fid_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] dst_q;

	// flow tables
	logic              pres_mem [FLOWS];
	logic [ADDR_W-1:0] hop_mem  [FLOWS];
	logic              pres_rd_q;
	logic [ADDR_W-1:0] hop_rd_q;
	logic [FIDX_W-1:0] clr_q;
	logic [FIDX_W-1:0] rd_idx;
	logic [FIDX_W-1:0] fidx;

	// uplink state
	logic [LOAD_W-1:0] load_q [HALF];
	logic [LOAD_W-1:0] load_d [HALF];
	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] lfsr_nx;

	// decoded addresses
	logic [KIND_W-1:0] me_kind, d_kind;
	logic [ADDR_W-1:0] me_x, me_q1, me_q2;
	logic [ADDR_W-1:0] d_x, d_q1, d_q2;
	logic [HIDX_W-1:0] me_r1, me_r2, d_r1, d_r2;

	// route decision
	logic              f_ok;
	logic              pres_c;
	logic              updir_c;
	logic [ADDR_W-1:0] ubase_c;
	logic [LOAD_W-1:0] min_c;
	logic [STAT_W-1:0] st_c;
	logic [ADDR_W-1:0] hop_c;
	logic              pick_c;
	logic              rec_c;
	logic              rmv_c;
	logic              rel_c;

	logic [STAT_W-1:0] st_q;
	logic [ADDR_W-1:0] hop_q;
	logic              pick_q;
	logic              rec_q;
	logic              rmv_q;
	logic              rel_q;
	logic [ADDR_W-1:0] ubase_q;
	logic [LOAD_W-1:0] min_q;

	// tie break
	logic [HALF-1:0]   mask_c;
	logic [HALF-1:0]   mask_q;
	logic [TIE_W-1:0]  ties_c;
	logic              mod_done;
	logic [TIE_W-1:0]  mod_rem;
	logic [TIE_W-1:0]  cnt_c;
	logic [HIDX_W-1:0] sel_c;
	logic [HIDX_W-1:0] up_q;

	// output register
	logic              out_valid_q;
	logic [ADDR_W-1:0] hop_addr_q;
	logic [STAT_W-1:0] status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_q <= '0;
		else if (cfg_we)
			node_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			act_q <= action;
			fid_q <= flow_id;
			src_q <= src_addr;
			dst_q <= dst_addr;
		end
	end

	assign rd_idx = FIDX_W'(flow_id);
	assign fidx   = FIDX_W'(fid_q);

	always_ff @(posedge clk) begin
		if (cmd.clr)
			pres_mem[clr_q] <= 1'b0;
		else if (cmd.fin && (rec_q || rmv_q))
			pres_mem[fidx] <= rec_q;
		if (cmd.acc)
			pres_rd_q <= pres_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.fin && rec_q)
			hop_mem[fidx] <= hop_q;
		if (cmd.acc)
			hop_rd_q <= hop_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr)
			clr_q <= FIDX_W'(clr_q + 1'b1);
	end

	ftll_addr_dec #(.TREE_K(TREE_K)) u_me_dec (
		.clk  (clk),
		.addr (node_q),
		.kind (me_kind),
		.x    (me_x),
		.q1   (me_q1),
		.q2   (me_q2),
		.r1   (me_r1),
		.r2   (me_r2)
	);

	ftll_addr_dec #(.TREE_K(TREE_K)) u_dst_dec (
		.clk  (clk),
		.addr (dst_q),
		.kind (d_kind),
		.x    (d_x),
		.q1   (d_q1),
		.q2   (d_q2),
		.r1   (d_r1),
		.r2   (d_r2)
	);

	assign f_ok    = FCMP_W'(fid_q) < FCMP_W'(FLOWS);
	assign pres_c  = pres_rd_q && f_ok;
	assign updir_c = (me_kind == KIND_EDGE) || (me_kind == KIND_AGGR);

	// address of uplink 0; the others follow in order
	always_comb begin
		if (me_kind == KIND_EDGE)
			ubase_c = ADDR_W'(AGGR_BASE + 1) + me_x - ADDR_W'(me_r1);
		else
			ubase_c = ADDR_W'(CORE_BASE + 1) + ADDR_W'(me_r1) * ADDR_W'(HALF);
	end

	always_comb begin
		min_c = load_q[0];
		for (int j = 1; j < HALF; j++)
			if (load_q[j] < min_c)
				min_c = load_q[j];
	end

	always_comb begin
		st_c   = STAT_OK;
		hop_c  = '0;
		pick_c = 1'b0;
		rec_c  = 1'b0;
		rmv_c  = 1'b0;
		rel_c  = 1'b0;
		if (me_kind == KIND_HOST) begin
			st_c = STAT_HOST;
			if (!act_q) begin
				if (node_q == dst_q)
					hop_c = '0;
				else if (node_q == src_q)
					hop_c = ADDR_W'(EDGE_BASE + 1) + me_q1;
				else
					st_c = STAT_NOROUTE;
			end
		end else if (act_q) begin
			if (!pres_c) begin
				st_c = STAT_ABSENT;
			end else begin
				hop_c = hop_rd_q;
				rmv_c = 1'b1;
				rel_c = 1'b1;
			end
		end else if (me_kind == KIND_NONE || d_kind != KIND_HOST || !f_ok) begin
			st_c = STAT_NOROUTE;
		end else begin
			rec_c = 1'b1;
			rel_c = pres_c;
			if (me_kind == KIND_CORE)
				// destination pod, aggregation position of this core group
				hop_c = ADDR_W'(AGGR_BASE + 1) + (d_q1 - ADDR_W'(d_r2)) + me_q1;
			else if (me_kind == KIND_AGGR && d_q2 == me_q1)
				hop_c = ADDR_W'(EDGE_BASE + 1) + d_q1;
			else if (me_kind == KIND_EDGE && d_q1 == me_x)
				hop_c = dst_q;
			else
				pick_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.route) begin
			st_q    <= st_c;
			hop_q   <= hop_c;
			pick_q  <= pick_c;
			rec_q   <= rec_c;
			rmv_q   <= rmv_c;
			rel_q   <= rel_c && updir_c;
			ubase_q <= ubase_c;
			min_q   <= min_c;
		end else if (cmd.sel) begin
			hop_q   <= ubase_q + ADDR_W'(sel_c);
		end
		if (cmd.ties)
			mask_q <= mask_c;
		if (cmd.sel)
			up_q <= sel_c;
	end

	always_comb begin
		for (int j = 0; j < HALF; j++)
			mask_c[j] = (load_q[j] == min_q);
	end

	assign ties_c  = TIE_W'($countones(mask_c));
	assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lfsr_q <= LFSR_SEED;
		else if (cmd.ties)
			lfsr_q <= lfsr_nx;
	end

	ftll_mod_unit #(.DEN_W(TIE_W)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ties),
		.num    (lfsr_nx),
		.den    (ties_c),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// pick the tied uplink whose rank among the ties equals the remainder
	always_comb begin
		cnt_c = '0;
		sel_c = '0;
		for (int j = 0; j < HALF; j++) begin
			if (mask_q[j]) begin
				if (cnt_c == mod_rem)
					sel_c = HIDX_W'(j);
				cnt_c = TIE_W'(cnt_c + 1'b1);
			end
		end
	end

	// release of the old hop first, then the count of a new uplink choice
	always_comb begin
		for (int j = 0; j < HALF; j++) begin
			load_d[j] = load_q[j];
			if (rel_q && hop_rd_q == ubase_q + ADDR_W'(j) && load_d[j] != '0)
				load_d[j] = load_d[j] - 1'b1;
			if (pick_q && up_q == HIDX_W'(j) && load_d[j] != LOAD_MAX)
				load_d[j] = load_d[j] + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HALF; j++)
				load_q[j] <= '0;
		end else if (cmd.fin) begin
			for (int j = 0; j < HALF; j++)
				load_q[j] <= load_d[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.fin)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			hop_addr_q <= hop_q;
			status_q   <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hop_addr  = hop_addr_q;
	assign status    = status_q;

	assign sts.clr_last  = (clr_q == FIDX_W'(FLOWS - 1));
	assign sts.need_pick = pick_c;
	assign sts.mod_done  = mod_done;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

FILE: sv/fat_tree_least_loaded_next_hop.sv
// top level of the fat tree switch that routes flows onto its least loaded uplink
//
//   channel   signals                                      handshake
//   config    cfg_we, cfg_wdata (node_addr)                write when cfg_we high
//   input     action, flow_id, src_addr, dst_addr          in_valid / in_ready
//   output    hop_addr, status                             out_valid / out_ready
//
// one item at a time; the next is taken only after write-back. the steps are accept,
// 3 decode stages of reciprocal multiplies and route, then, when an uplink is chosen,
// tie count, the byte-per-cycle remainder unit and select, and last write-back.
// after reset the flow-present memory is cleared one entry a cycle, every entry, before
// the first item is taken; configuration writes are taken throughout.
// a finished result waits in the output register; write-back stalls only while it is full.
module fat_tree_least_loaded_next_hop #(
	parameter int TREE_K = ftll_pkg::TREE_K_DEF,
	parameter int FLOWS  = ftll_pkg::FLOWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ftll_pkg::ADDR_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [ftll_pkg::FLOW_W-1:0]  flow_id,
	input  logic [ftll_pkg::ADDR_W-1:0]  src_addr,
	input  logic [ftll_pkg::ADDR_W-1:0]  dst_addr,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ftll_pkg::ADDR_W-1:0]  hop_addr,
	output logic [ftll_pkg::STAT_W-1:0]  status
);
	import ftll_pkg::*;

	ftll_cmd_t cmd;
	ftll_sts_t sts;

	ftll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ftll_dp #(
		.TREE_K (TREE_K),
		.FLOWS  (FLOWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.action    (action),
		.flow_id   (flow_id),
		.src_addr  (src_addr),
		.dst_addr  (dst_addr),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.hop_addr  (hop_addr),
		.status    (status)
	);

endmodule
